>>> rtl/tplm_pkg.sv
// shared types and constants of the two-level page table manager
`timescale 1ns / 1ps

package tplm_pkg;

  localparam int unsigned ENTRIES = 1024;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned PAGE_W  = 20;
  localparam int unsigned FLAG_W_BITS = 3;
  localparam int unsigned TBL_W   = PAGE_W + FLAG_W_BITS;

  localparam logic [IDX_W-1:0] RESERVED_IDX = 10'h3ff;
  localparam logic [31:0]      USER_TOP     = 32'hc000_0000;

  localparam logic [2:0] FLAG_P  = 3'b001;
  localparam logic [2:0] FLAG_W  = 3'b010;
  localparam logic [2:0] FLAG_U  = 3'b100;
  localparam logic [2:0] FLAG_PU = FLAG_P | FLAG_U;

  localparam logic OP_MAP   = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_RANGE    = 2'd1;
  localparam logic [1:0] STATUS_NO_SLOT  = 2'd2;
  localparam logic [1:0] STATUS_RESERVED = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [31:0] vaddr;
    logic [31:0] paddr;
    logic        user_mode;
    logic [31:0] range_length;
  } tplm_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] entry_value;
  } tplm_out_t;

  typedef struct packed {
    logic        go;
    logic [31:0] start;
    logic [31:0] len;
  } walk_req_t;

  typedef struct packed {
    logic done;
    logic fail;
  } walk_rsp_t;

endpackage

>>> rtl/tplm_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module tplm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/tplm_walk.sv
// user range walker: one directory and one table read per page, pipelined
`timescale 1ns / 1ps

module tplm_walk import tplm_pkg::*; #(
  parameter int TABLE_SLOTS = 64,
  localparam int SLOT_W = $clog2(TABLE_SLOTS),
  localparam int DIR_W  = SLOT_W + FLAG_W_BITS,
  localparam int TBL_AW = SLOT_W + IDX_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  walk_req_t         req,
  output walk_rsp_t         rsp,
  output logic              dir_re,
  output logic [IDX_W-1:0]  dir_raddr,
  input  logic [DIR_W-1:0]  dir_rdata,
  output logic              tbl_re,
  output logic [TBL_AW-1:0] tbl_raddr,
  input  logic [TBL_W-1:0]  tbl_rdata
);

  typedef enum logic [2:0] {
    W_IDLE = 3'b001,
    W_SUM  = 3'b010,
    W_RUN  = 3'b100
  } walk_state_t;

  walk_state_t       state_r, state_nxt;
  logic [31:0]       va_r, va_nxt;
  logic [31:0]       lenm1_r, lenm1_nxt;
  logic              zero_r, zero_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [PAGE_W-1:0] last_r, last_nxt;
  logic              issuing_r, issuing_nxt;
  logic              p1_v_r, p1_v_nxt;
  logic [IDX_W-1:0]  p1_idx_r, p1_idx_nxt;
  logic              p2_v_r, p2_v_nxt;
  logic [32:0]       end_sum;
  logic              fail_w;

  always_comb begin
    state_nxt   = state_r;
    va_nxt      = va_r;
    lenm1_nxt   = lenm1_r;
    zero_nxt    = zero_r;
    page_nxt    = page_r;
    last_nxt    = last_r;
    issuing_nxt = issuing_r;
    p1_v_nxt    = p1_v_r;
    p1_idx_nxt  = p1_idx_r;
    p2_v_nxt    = p2_v_r;
    rsp         = '0;
    dir_re      = 1'b0;
    dir_raddr   = page_r[PAGE_W-1:IDX_W];
    tbl_re      = 1'b0;
    tbl_raddr   = {dir_rdata[DIR_W-1:FLAG_W_BITS], p1_idx_r};
    end_sum     = {1'b0, va_r} + {1'b0, lenm1_r};
    fail_w      = 1'b0;

    unique case (state_r)
      W_IDLE: begin
        if (req.go) begin
          va_nxt    = req.start;
          lenm1_nxt = req.len - 32'd1;
          zero_nxt  = (req.len == 32'd0);
          state_nxt = W_SUM;
        end
      end
      W_SUM: begin
        priority if (va_r >= USER_TOP) begin
          rsp       = '{done: 1'b1, fail: 1'b1};
          state_nxt = W_IDLE;
        end else if (zero_r) begin
          rsp       = '{done: 1'b1, fail: 1'b0};
          state_nxt = W_IDLE;
        end else if (end_sum >= {1'b0, USER_TOP}) begin
          rsp       = '{done: 1'b1, fail: 1'b1};
          state_nxt = W_IDLE;
        end else begin
          page_nxt    = va_r[31:12];
          last_nxt    = end_sum[31:12];
          issuing_nxt = 1'b1;
          p1_v_nxt    = 1'b0;
          p2_v_nxt    = 1'b0;
          state_nxt   = W_RUN;
        end
      end
      W_RUN: begin
        p1_v_nxt   = issuing_r;
        p1_idx_nxt = page_r[IDX_W-1:0];
        if (issuing_r) begin
          dir_re = 1'b1;
          if (page_r == last_r) begin
            issuing_nxt = 1'b0;
          end else begin
            page_nxt = page_r + PAGE_W'(1);
          end
        end
        p2_v_nxt = 1'b0;
        if (p1_v_r) begin
          if ((dir_rdata[FLAG_W_BITS-1:0] & FLAG_PU) == FLAG_PU) begin
            tbl_re   = 1'b1;
            p2_v_nxt = 1'b1;
          end else begin
            fail_w = 1'b1;
          end
        end
        if (p2_v_r && ((tbl_rdata[FLAG_W_BITS-1:0] & FLAG_PU) != FLAG_PU)) begin
          fail_w = 1'b1;
        end
        if (fail_w) begin
          rsp         = '{done: 1'b1, fail: 1'b1};
          issuing_nxt = 1'b0;
          p1_v_nxt    = 1'b0;
          p2_v_nxt    = 1'b0;
          state_nxt   = W_IDLE;
        end else if (!issuing_r && !p1_v_r && !p2_v_r) begin
          rsp       = '{done: 1'b1, fail: 1'b0};
          state_nxt = W_IDLE;
        end
      end
      default: begin
        state_nxt = W_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= W_IDLE;
      issuing_r <= 1'b0;
      p1_v_r    <= 1'b0;
      p2_v_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      issuing_r <= issuing_nxt;
      p1_v_r    <= p1_v_nxt;
      p2_v_r    <= p2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    va_r     <= va_nxt;
    lenm1_r  <= lenm1_nxt;
    zero_r   <= zero_nxt;
    page_r   <= page_nxt;
    last_r   <= last_nxt;
    p1_idx_r <= p1_idx_nxt;
  end

endmodule

>>> rtl/two_level_page_table_manager.sv
// two-level page table manager: directory ram, table pool ram, map and check control
// map and check: a map into a present table or a refused map is settled in S_MAP; when a
//   new table is allocated, S_ZERO clears it first; a check is settled by its bounds or
//   walks its user pages; the manager returns to S_IDLE before it takes the next transfer
// reset: an init pass loads the directory and the identity tables; in_stall stays high
//   during it
`timescale 1ns / 1ps

module two_level_page_table_manager import tplm_pkg::*; #(
  parameter int TABLE_SLOTS    = 64,
  parameter int PRELOAD_TABLES = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tplm_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output tplm_out_t out_data
);

  localparam int SLOT_W    = $clog2(TABLE_SLOTS);
  localparam int DIR_W     = SLOT_W + FLAG_W_BITS;
  localparam int TBL_AW    = SLOT_W + IDX_W;
  localparam int TBL_DEPTH = TABLE_SLOTS * ENTRIES;
  localparam int CNT_W     = $clog2(TABLE_SLOTS + 1);
  localparam int INIT_LEN  = ENTRIES * ((PRELOAD_TABLES > 0) ? PRELOAD_TABLES : 1);
  localparam int INIT_W    = $clog2(INIT_LEN);
  localparam logic [INIT_W:0] ID_END  = (INIT_W + 1)'(PRELOAD_TABLES * ENTRIES);
  localparam logic [INIT_W:0] DIR_END = (INIT_W + 1)'(ENTRIES);

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_MAP  = 6'b000100,
    S_ZERO = 6'b001000,
    S_WALK = 6'b010000,
    S_HOLD = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [INIT_W-1:0] init_cnt_r, init_cnt_nxt;
  logic [CNT_W-1:0] next_free_r, next_free_nxt;
  tplm_in_t         req_r, req_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [IDX_W-1:0] zero_cnt_r, zero_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  tplm_out_t        out_data_r, out_data_nxt;
  tplm_out_t        hold_r, hold_nxt;

  logic             accept;
  logic             out_free;
  logic             fin;
  tplm_out_t        fin_data;
  logic [2:0]       flags;
  logic [TBL_W-1:0] entry_tbl;
  logic [31:0]      entry_out;
  logic [IDX_W-1:0] di;
  logic [IDX_W-1:0] ti;

  logic              dir_we, dir_re;
  logic [IDX_W-1:0]  dir_waddr, dir_raddr;
  logic [DIR_W-1:0]  dir_wdata, dir_rdata;
  logic              tbl_we, tbl_re;
  logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
  logic [TBL_W-1:0]  tbl_wdata, tbl_rdata;

  logic              w_dir_re, w_tbl_re;
  logic [IDX_W-1:0]  w_dir_raddr;
  logic [TBL_AW-1:0] w_tbl_raddr;
  walk_req_t         walk_req;
  walk_rsp_t         walk_rsp;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign flags     = req_r.user_mode ? (FLAG_P | FLAG_W | FLAG_U) : (FLAG_P | FLAG_W);
  assign entry_tbl = {req_r.paddr[31:12], flags};
  assign entry_out = {req_r.paddr[31:12], 9'd0, flags};
  assign di        = req_r.vaddr[31:22];
  assign ti        = req_r.vaddr[21:12];

  always_comb begin
    state_nxt     = state_r;
    init_cnt_nxt  = init_cnt_r;
    next_free_nxt = next_free_r;
    req_nxt       = req_r;
    slot_nxt      = slot_r;
    zero_cnt_nxt  = zero_cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    hold_nxt      = hold_r;
    fin           = 1'b0;
    fin_data      = '0;

    walk_req.go    = 1'b0;
    walk_req.start = in_data.vaddr;
    walk_req.len   = in_data.range_length;

    dir_we    = 1'b0;
    dir_waddr = di;
    dir_wdata = '0;
    dir_re    = w_dir_re;
    dir_raddr = w_dir_raddr;
    tbl_we    = 1'b0;
    tbl_waddr = {dir_rdata[DIR_W-1:FLAG_W_BITS], ti};
    tbl_wdata = entry_tbl;
    tbl_re    = w_tbl_re;
    tbl_raddr = w_tbl_raddr;

    // output register drains on a transfer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT: begin
        dir_we    = ({1'b0, init_cnt_r} < DIR_END);
        dir_waddr = init_cnt_r[IDX_W-1:0];
        dir_wdata = (init_cnt_r[IDX_W-1:0] < IDX_W'(PRELOAD_TABLES)) ?
                    {SLOT_W'(init_cnt_r[IDX_W-1:0]), FLAG_P | FLAG_W} : '0;
        tbl_we    = ({1'b0, init_cnt_r} < ID_END);
        tbl_waddr = TBL_AW'(init_cnt_r);
        tbl_wdata = {PAGE_W'(init_cnt_r), FLAG_P | FLAG_W};
        if (init_cnt_r == INIT_W'(INIT_LEN - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          init_cnt_nxt = init_cnt_r + INIT_W'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          req_nxt = in_data;
          if (in_data.opcode == OP_CHECK) begin
            walk_req.go = 1'b1;
            state_nxt   = S_WALK;
          end else begin
            dir_re    = 1'b1;
            dir_raddr = in_data.vaddr[31:22];
            state_nxt = S_MAP;
          end
        end
      end
      S_MAP: begin
        priority if (di == RESERVED_IDX) begin
          fin      = 1'b1;
          fin_data = '{status: STATUS_RESERVED, entry_value: 32'd0};
        end else if ((dir_rdata[FLAG_W_BITS-1:0] & FLAG_P) != 3'd0) begin
          if (req_r.user_mode) begin
            dir_we    = 1'b1;
            dir_wdata = dir_rdata | DIR_W'(FLAG_U);
          end
          tbl_we   = 1'b1;
          fin      = 1'b1;
          fin_data = '{status: STATUS_OK, entry_value: entry_out};
        end else if (next_free_r >= CNT_W'(TABLE_SLOTS)) begin
          fin      = 1'b1;
          fin_data = '{status: STATUS_NO_SLOT, entry_value: 32'd0};
        end else begin
          slot_nxt      = next_free_r[SLOT_W-1:0];
          next_free_nxt = next_free_r + CNT_W'(1);
          dir_we        = 1'b1;
          dir_wdata     = {next_free_r[SLOT_W-1:0], flags};
          zero_cnt_nxt  = '0;
          state_nxt     = S_ZERO;
        end
      end
      S_ZERO: begin
        // new table is cleared, the mapped entry lands on its own index
        tbl_we       = 1'b1;
        tbl_waddr    = {slot_r, zero_cnt_r};
        tbl_wdata    = (zero_cnt_r == ti) ? entry_tbl : '0;
        zero_cnt_nxt = zero_cnt_r + IDX_W'(1);
        if (zero_cnt_r == IDX_W'(ENTRIES - 1)) begin
          fin      = 1'b1;
          fin_data = '{status: STATUS_OK, entry_value: entry_out};
        end
      end
      S_WALK: begin
        if (walk_rsp.done) begin
          fin      = 1'b1;
          fin_data = '{status: walk_rsp.fail ? STATUS_RANGE : STATUS_OK,
                       entry_value: 32'd0};
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = hold_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = fin_data;
        state_nxt     = S_IDLE;
      end else begin
        hold_nxt  = fin_data;
        state_nxt = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_cnt_r  <= '0;
      next_free_r <= CNT_W'(PRELOAD_TABLES);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_cnt_r  <= init_cnt_nxt;
      next_free_r <= next_free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    slot_r     <= slot_nxt;
    zero_cnt_r <= zero_cnt_nxt;
    out_data_r <= out_data_nxt;
    hold_r     <= hold_nxt;
  end

  tplm_ram #(
    .WIDTH (DIR_W),
    .DEPTH (ENTRIES)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .re    (dir_re),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  tplm_ram #(
    .WIDTH (TBL_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  tplm_walk #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (walk_req),
    .rsp       (walk_rsp),
    .dir_re    (w_dir_re),
    .dir_raddr (w_dir_raddr),
    .dir_rdata (dir_rdata),
    .tbl_re    (w_tbl_re),
    .tbl_raddr (w_tbl_raddr),
    .tbl_rdata (tbl_rdata)
  );

endmodule
